// File: rtl/core/line_field_byte_selector_core_macros.svh
// Assertion macros shared by the line field and byte selector RTL.
`ifndef LINE_FIELD_BYTE_SELECTOR_CORE_MACROS_SVH
`define LINE_FIELD_BYTE_SELECTOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Generic clocked assertion with explicit clock and active-low reset.
`define LFBS_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the block clock and reset.
`define LFBS_ASSERT(label, prop, msg) \
  `LFBS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define LFBS_ASSERT_CLK(label, clk, rstn, prop, msg)
`define LFBS_ASSERT(label, prop, msg)
`endif

`endif

// File: rtl/core/lfbs_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants and types of the line field and byte selector.
package lfbs_pkg;

  // Default sizes
  localparam int unsigned FirstFieldBytesDef = 63;
  localparam int unsigned MaskPositionsDef   = 64;

  // Line position counter
  localparam int unsigned PosW   = 16;
  localparam logic [PosW-1:0] PosOne = 16'd1;
  localparam logic [PosW-1:0] PosMax = 16'hFFFF;

  // Byte codes
  localparam logic [7:0] NlByte       = 8'd10;
  localparam logic [7:0] DelimDefault = 8'd9;

  // Configuration port
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgDataW = 64;

  // Register indexes (byte address / 8)
  localparam logic [2:0] RegFieldMode = 3'd0;
  localparam logic [2:0] RegDelimiter = 3'd1;
  localparam logic [2:0] RegSuppress  = 3'd2;
  localparam logic [2:0] RegPosMask   = 3'd3;
  localparam logic [2:0] RegOpenFrom  = 3'd4;

  // Scalar configuration handed to the line controller
  typedef struct packed {
    logic            field_mode;
    logic [7:0]      delimiter_byte;
    logic            suppress_undelimited;
    logic [PosW-1:0] open_from;
  } cfg_t;

endpackage

// File: rtl/core/lfbs_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module lfbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 63
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lfbs_cfg.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module lfbs_cfg #(
  parameter int unsigned MaskPositions = lfbs_pkg::MaskPositionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfbs_pkg::CfgAddrW-1:0] paddr,
  input  logic [lfbs_pkg::CfgDataW-1:0] pwdata,
  output logic [lfbs_pkg::CfgDataW-1:0] prdata,
  output lfbs_pkg::cfg_t                cfg_o,
  output logic [MaskPositions-1:0]      mask_o
);

  logic                         field_mode_q;
  logic [7:0]                   delim_q;
  logic                         suppress_q;
  logic [MaskPositions-1:0]     mask_q;
  logic [lfbs_pkg::PosW-1:0]    open_from_q;
  logic                         wr_en;
  logic [2:0]                   reg_idx;

  assign reg_idx = paddr[lfbs_pkg::CfgAddrW-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mode_q <= 1'b0;
      delim_q      <= lfbs_pkg::DelimDefault;
      suppress_q   <= 1'b0;
      mask_q       <= '0;
      open_from_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        lfbs_pkg::RegFieldMode: field_mode_q <= pwdata[0];
        lfbs_pkg::RegDelimiter: delim_q      <= pwdata[7:0];
        lfbs_pkg::RegSuppress:  suppress_q   <= pwdata[0];
        lfbs_pkg::RegPosMask:   mask_q       <= pwdata[MaskPositions-1:0];
        lfbs_pkg::RegOpenFrom:  open_from_q  <= pwdata[lfbs_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      lfbs_pkg::RegFieldMode: prdata = lfbs_pkg::CfgDataW'(field_mode_q);
      lfbs_pkg::RegDelimiter: prdata = lfbs_pkg::CfgDataW'(delim_q);
      lfbs_pkg::RegSuppress:  prdata = lfbs_pkg::CfgDataW'(suppress_q);
      lfbs_pkg::RegPosMask:   prdata = lfbs_pkg::CfgDataW'(mask_q);
      lfbs_pkg::RegOpenFrom:  prdata = lfbs_pkg::CfgDataW'(open_from_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.field_mode           = field_mode_q;
  assign cfg_o.delimiter_byte       = delim_q;
  assign cfg_o.suppress_undelimited = suppress_q;
  assign cfg_o.open_from            = open_from_q;
  assign mask_o                     = mask_q;

endmodule

// File: rtl/core/lfbs_ctrl.sv
`timescale 1ns / 1ps
// Line controller: per-line state, field-one store and output register.
`include "line_field_byte_selector_core_macros.svh"
module lfbs_ctrl #(
  parameter int unsigned FirstFieldBytes = lfbs_pkg::FirstFieldBytesDef,
  parameter int unsigned MaskPositions   = lfbs_pkg::MaskPositionsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfbs_pkg::cfg_t           cfg_i,
  input  logic [MaskPositions-1:0] mask_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_eos_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     out_last_o,
  output logic                     out_trunc_o
);

  localparam int unsigned CntW    = $clog2(FirstFieldBytes + 1);
  localparam int unsigned AddrW   = FirstFieldBytes > 1 ? $clog2(FirstFieldBytes) : 1;
  localparam int unsigned IdxW    = $clog2(MaskPositions);
  localparam int unsigned MaskPad = 1 << IdxW;
  localparam int unsigned PosW    = lfbs_pkg::PosW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TRAIL
  } state_e;

  // Position k is selected by the mask or by the open-ended start
  function automatic logic sel_pos(input logic [PosW-1:0]    k,
                                   input logic [MaskPad-1:0] mask,
                                   input logic [PosW-1:0]    open_from);
    logic [PosW-1:0] km1;
    logic            hit_mask;
    logic            hit_open;
    km1      = k - lfbs_pkg::PosOne;
    hit_mask = (k != '0) && (k <= PosW'(MaskPositions)) && mask[km1[IdxW-1:0]];
    hit_open = (open_from != '0) && (k >= open_from);
    return hit_mask || hit_open;
  endfunction

  state_e            state_q;

  // Line state
  logic [PosW-1:0]   pos_q, pos_d;
  logic              seen_q, seen_d;
  logic              emitted_q, emitted_d;
  logic              stream_q, stream_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;

  // Flush bookkeeping
  logic [CntW-1:0]   flush_cnt_q;
  logic [CntW-1:0]   rd_idx_q;
  logic              flush_trunc_q;
  logic              trail_q;
  logic [7:0]        trail_byte_q;

  // Output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              out_trunc_q;

  logic [MaskPad-1:0] mask_pad;
  logic [PosW-1:0]   pos_inc;
  logic              sel_cur, sel_next, sel_one;
  logic              is_delim, is_nl;
  logic              out_free, acc;
  logic              out_load;
  logic              pass, emitted_n;
  logic              emit_v, start_flush, trail_v, store_we;
  logic [7:0]        emit_byte, trail_byte;
  logic [CntW-1:0]   rd_nxt;
  logic              more;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  assign mask_pad = MaskPad'(mask_i);
  assign pos_inc  = (pos_q == lfbs_pkg::PosMax) ? pos_q : pos_q + lfbs_pkg::PosOne;
  assign sel_cur  = sel_pos(pos_q, mask_pad, cfg_i.open_from);
  assign sel_next = sel_pos(pos_inc, mask_pad, cfg_i.open_from);
  assign sel_one  = sel_pos(lfbs_pkg::PosOne, mask_pad, cfg_i.open_from);

  assign is_delim = !in_eos_i && (in_byte_i == cfg_i.delimiter_byte);
  assign is_nl    = !in_eos_i && (in_byte_i == lfbs_pkg::NlByte);

  // Handshake: one item at a time, only with a free output slot
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;

  // Effect of one accepted item on the line state
  always_comb begin
    pos_d       = pos_q;
    seen_d      = seen_q;
    emitted_d   = emitted_q;
    stream_d    = stream_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pass        = 1'b0;
    emitted_n   = emitted_q;
    emit_v      = 1'b0;
    emit_byte   = in_byte_i;
    start_flush = 1'b0;
    trail_v     = 1'b0;
    trail_byte  = lfbs_pkg::NlByte;
    store_we    = 1'b0;
    if (!cfg_i.field_mode) begin
      // Byte positions
      if (in_eos_i) begin
        pos_d     = lfbs_pkg::PosOne;
        seen_d    = 1'b0;
        emitted_d = 1'b0;
        stream_d  = 1'b0;
        cnt_d     = '0;
        ovf_d     = 1'b0;
      end else if (is_nl) begin
        emit_v = 1'b1;
        pos_d  = lfbs_pkg::PosOne;
      end else begin
        emit_v = sel_cur;
        pos_d  = pos_inc;
      end
    end else if (in_eos_i || is_delim || is_nl) begin
      // End of a field: decide on field one, then join or end the line
      if (pos_q == lfbs_pkg::PosOne) begin
        pass = (sel_one && (!cfg_i.suppress_undelimited || seen_q || is_delim)) ||
               (!cfg_i.suppress_undelimited && (in_eos_i || is_nl));
        emitted_n   = emitted_q | pass;
        start_flush = pass && (cnt_q != '0);
        cnt_d       = '0;
        ovf_d       = 1'b0;
      end
      seen_d = seen_q | is_delim;
      if (is_nl || in_eos_i) begin
        trail_v    = is_nl && emitted_n;
        trail_byte = lfbs_pkg::NlByte;
        pos_d      = lfbs_pkg::PosOne;
        seen_d     = 1'b0;
        emitted_d  = 1'b0;
        stream_d   = 1'b0;
        cnt_d      = '0;
        ovf_d      = 1'b0;
      end else begin
        pos_d      = pos_inc;
        stream_d   = sel_next;
        trail_v    = sel_next && emitted_n;
        trail_byte = cfg_i.delimiter_byte;
        emitted_d  = emitted_n | sel_next;
      end
      emit_v    = trail_v && !start_flush;
      emit_byte = trail_byte;
    end else if (pos_q == lfbs_pkg::PosOne) begin
      // Field one is buffered until its end is known
      if (cnt_q < CntW'(FirstFieldBytes)) begin
        store_we = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end else begin
      emit_v = stream_q;
    end
  end

  // Flush read pointer
  assign rd_nxt    = rd_idx_q + 1'b1;
  assign more      = rd_nxt < flush_cnt_q;
  assign ram_re    = (acc && start_flush) || ((state_q == ST_FLUSH) && out_free && more);
  assign ram_raddr = (state_q == ST_FLUSH) ? rd_nxt[AddrW-1:0] : '0;

  // Output register takes a new item
  assign out_load = ((state_q == ST_IDLE) && acc && emit_v) ||
                    (((state_q == ST_FLUSH) || (state_q == ST_TRAIL)) && out_free);

  lfbs_ram #(
    .Width (8),
    .Depth (FirstFieldBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (acc && store_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, line state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pos_q         <= lfbs_pkg::PosOne;
      seen_q        <= 1'b0;
      emitted_q     <= 1'b0;
      stream_q      <= 1'b0;
      cnt_q         <= '0;
      ovf_q         <= 1'b0;
      flush_cnt_q   <= '0;
      rd_idx_q      <= '0;
      flush_trunc_q <= 1'b0;
      trail_q       <= 1'b0;
      trail_byte_q  <= '0;
      out_valid_q   <= 1'b0;
      out_byte_q    <= '0;
      out_last_q    <= 1'b0;
      out_trunc_q   <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            pos_q     <= pos_d;
            seen_q    <= seen_d;
            emitted_q <= emitted_d;
            stream_q  <= stream_d;
            cnt_q     <= cnt_d;
            ovf_q     <= ovf_d;
            if (emit_v) begin
              out_byte_q  <= emit_byte;
              out_last_q  <= 1'b1;
              out_trunc_q <= 1'b0;
            end
            if (start_flush) begin
              state_q       <= ST_FLUSH;
              rd_idx_q      <= '0;
              flush_cnt_q   <= cnt_q;
              flush_trunc_q <= ovf_q;
              trail_q       <= trail_v;
              trail_byte_q  <= trail_byte;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_byte_q  <= ram_rdata;
            out_last_q  <= !more && !trail_q;
            out_trunc_q <= flush_trunc_q;
            rd_idx_q    <= rd_nxt;
            if (!more) begin
              state_q <= trail_q ? ST_TRAIL : ST_IDLE;
            end
          end
        end
        ST_TRAIL: begin
          if (out_free) begin
            out_byte_q  <= trail_byte_q;
            out_last_q  <= 1'b1;
            out_trunc_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;

  // Checks
  `LFBS_ASSERT(a_no_store_write_busy, (state_q != ST_IDLE) |-> !(acc && store_we), "store written during flush")
  `LFBS_ASSERT(a_cnt_bound, cnt_q <= CntW'(FirstFieldBytes), "field one count beyond store depth")
  `LFBS_ASSERT(a_rd_in_range, (state_q == ST_FLUSH) |-> (rd_idx_q < flush_cnt_q), "flush read beyond stored bytes")
  `LFBS_ASSERT(a_flush_ends_last, $fell(state_q != ST_IDLE) |-> (out_valid_q && out_last_q), "flush ended without final item")

endmodule

// File: rtl/core/line_field_byte_selector_core.sv
`timescale 1ns / 1ps
// Top level of the line field and byte selector (cut -b / cut -f style).
//
// Input stream: one text byte per item on s_axis_tdata, or an end-of-stream
// mark on s_axis_tlast (byte ignored). Output stream: one selected byte per
// item on m_axis_tdata; m_axis_tlast marks the final output of an input
// item, m_axis_tuser flags bytes of a buffered first field that overflowed.
// Registers are written over the APB-style port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A result is registered in the output register in the cycle after its
// input item is accepted. Byte mode and later fields sustain one item per
// cycle while the receiver is ready. At the end of field one in field mode,
// the N buffered bytes are read back from the field store, one byte per
// cycle through its single read port while the receiver is ready, then any
// following delimiter or newline; input is held off (s_axis_tready low)
// until all reach the output register. When the receiver stalls, the output
// item holds and s_axis_tready drops. Reset clears the line state and
// registers (delimiter back to tab); the field store needs no clearing pass.
module line_field_byte_selector_core #(
  parameter int unsigned FirstFieldBytes = lfbs_pkg::FirstFieldBytesDef,
  parameter int unsigned MaskPositions   = lfbs_pkg::MaskPositionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // end_of_stream
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] out_byte
  output logic                          m_axis_tlast,  // last_of_run
  output logic                          m_axis_tuser,  // [0] field_truncated
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfbs_pkg::CfgAddrW-1:0] paddr,
  input  logic [lfbs_pkg::CfgDataW-1:0] pwdata,
  output logic [lfbs_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  lfbs_pkg::cfg_t           cfg;
  logic [MaskPositions-1:0] mask;

  // No wait states
  assign pready = 1'b1;

  lfbs_cfg #(
    .MaskPositions (MaskPositions)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg),
    .mask_o  (mask)
  );

  lfbs_ctrl #(
    .FirstFieldBytes (FirstFieldBytes),
    .MaskPositions   (MaskPositions)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mask_i      (mask),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_trunc_o (m_axis_tuser)
  );

endmodule
